/* hdl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and constants of the character LCD scrolling terminal:
// operation codes, control characters, LCD instruction bytes, row base
// addresses and the request bundle of the row store.
// ----------------------------------------------------------------------------
package clt_pkg;

   // terminal operations
   localparam logic [2:0] OP_PUT_CHAR = 3'd0;
   localparam logic [2:0] OP_CLEAR    = 3'd1;
   localparam logic [2:0] OP_SET_POS  = 3'd2;
   localparam logic [2:0] OP_SAVE     = 3'd3;
   localparam logic [2:0] OP_RESTORE  = 3'd4;

   // control characters
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // LCD instruction bytes and settle times
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] ADDR_MASK    = 8'h7F;
   localparam logic [2:0] SETTLE_CLEAR = 3'd5;
   localparam logic [2:0] SETTLE_WRITE = 3'd2;

   // slots reserved per stored row (widest panel line)
   localparam int LINE_SLOTS = 16;

   // DDRAM start address of each panel row
   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

   // set-address instruction for column x of row y
   function automatic logic [7:0] set_addr_cmd(input logic [3:0] x, input logic [1:0] y);
      return CMD_SET_ADDR | ((ROW_BASE[y] + {4'b0000, x}) & ADDR_MASK);
   endfunction

   // row store request: one write, one read, scroll and clear per cycle
   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_row;
      logic [3:0] wr_col;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [1:0] rd_row;
      logic [3:0] rd_col;
      logic       scroll;
      logic       clear_all;
   } store_req_type;

endpackage

/* hdl/clt_row_store.sv */
// ----------------------------------------------------------------------------
// clt_row_store
// Text store of the panel rows below the top row. A synchronous RAM with a
// registered read, a valid bit per slot (an invalid slot reads as a space)
// and a rotating base row, so that a scroll retires the oldest row by
// clearing its valid bits instead of copying the store.
// ----------------------------------------------------------------------------
module clt_row_store import clt_pkg::*; #(
   parameter int ROWS = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type store_req,
   output logic [7:0]    rd_byte
);

   localparam int STORE_ROWS = ROWS - 1;
   localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int SUM_W      = ROW_W + 1;
   localparam int DEPTH      = STORE_ROWS * LINE_SLOTS;
   localparam int ADDR_W     = $clog2(DEPTH);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // physical row of a logical row, relative to the rotating base
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                 input logic [1:0] lrow);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(lrow);
      if (sum >= SUM_W'(STORE_ROWS)) begin
         sum = sum - SUM_W'(STORE_ROWS);
      end
      return ROW_W'(sum);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [3:0] col);
      return ADDR_W'({prow, col});
   endfunction

   assign wr_addr = slot_addr(phys_row(base_ff, store_req.wr_row), store_req.wr_col);
   assign rd_addr = slot_addr(phys_row(base_ff, store_req.rd_row), store_req.rd_col);

   // valid bits and base row
   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      if (store_req.clear_all) begin
         valid_in = '0;
      end else if (store_req.scroll) begin
         // oldest row becomes the new bottom row, blank
         for (int j = 0; j < LINE_SLOTS; j++) begin
            valid_in[slot_addr(base_ff, 4'(j))] = 1'b0;
         end
         base_in = (base_ff == ROW_W'(STORE_ROWS - 1)) ? '0 : base_ff + 1'b1;
      end else if (store_req.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         base_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         base_ff  <= base_in;
      end
   end

   // RAM, one write and one registered read
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_byte = rd_valid_ff ? rd_data_ff : CHAR_SPACE;

endmodule

/* hdl/char_lcd_scrolling_terminal_unit.sv */
// ----------------------------------------------------------------------------
// char_lcd_scrolling_terminal_unit
// Turns terminal requests into character LCD bus writes, with scrolling.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken only while the sequencer is idle,
// and its bus writes then leave one per cycle while rsp_stall is low. A
// scroll adds the clear, (ROWS-1)*(COLUMNS+1) row address and character
// writes and the bottom row address to the character write or to up to two
// cursor writes. The row store RAM delivers one stored character per cycle
// through its single read port while rsp_stall is low. Every write leaves
// through an output register, so the next write is formed while the current
// one waits. auto_return may be written at any time the unit is idle;
// csr_ready is always high.
// ----------------------------------------------------------------------------
module char_lcd_scrolling_terminal_unit import clt_pkg::*; #(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_character,
   input  logic [3:0] req_pos_x,
   input  logic [1:0] req_pos_y,
   // bus write channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_command,
   output logic [7:0] rsp_bus_byte,
   output logic [2:0] rsp_settle_ms,
   output logic       rsp_last,
   // register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_auto_return
);

   localparam logic [3:0] LAST_COL       = 4'(COLUMNS - 1);
   localparam logic [1:0] LAST_ROW       = 2'(ROWS - 1);
   localparam logic [1:0] LAST_STORE_ROW = 2'(ROWS - 2);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_FIRST     = 8'b0000_0010,
      S_CLEAR     = 8'b0000_0100,
      S_ROW_ADDR  = 8'b0000_1000,
      S_ROW_DATA  = 8'b0001_0000,
      S_LAST_ADDR = 8'b0010_0000,
      S_TAIL0     = 8'b0100_0000,
      S_TAIL1     = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [3:0]    cursor_col_ff, cursor_col_in;
   logic [1:0]    cursor_row_ff, cursor_row_in;
   logic          saved_valid_ff, saved_valid_in;
   logic [3:0]    saved_col_ff, saved_col_in;
   logic [1:0]    saved_row_ff, saved_row_in;
   logic          auto_return_ff, auto_return_in;
   logic          first_clear_ff, first_clear_in;
   logic [7:0]    first_byte_ff, first_byte_in;
   logic          scroll_ff, scroll_in;
   logic [1:0]    tail_cnt_ff, tail_cnt_in;
   logic [7:0]    tail0_ff, tail0_in;
   logic [7:0]    tail1_ff, tail1_in;
   logic [1:0]    row_cnt_ff, row_cnt_in;
   logic [3:0]    col_cnt_ff, col_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [2:0]    rsp_ms_ff, rsp_ms_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_accept, slot_free, emitting;
   logic          dec_first, dec_first_clear, dec_scroll;
   logic [1:0]    dec_tail_cnt;
   logic [7:0]    dec_tail0, dec_tail1;
   logic [3:0]    dec_col;
   logic [1:0]    dec_row, lf_row;
   logic          dec_wr, dec_clear_all;
   logic          emit_cmd, emit_last;
   logic [7:0]    emit_byte;
   logic [2:0]    emit_ms;
   state_type     emit_next;
   state_type     after_first, after_scroll;
   store_req_type store_req;
   logic [7:0]    store_byte;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign emitting   = slot_free && (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   // request decode: plan of writes and the cursor afterwards
   always_comb begin
      dec_first       = 1'b0;
      dec_first_clear = 1'b0;
      dec_scroll      = 1'b0;
      dec_tail_cnt    = 2'd0;
      dec_tail0       = set_addr_cmd(cursor_col_ff, cursor_row_ff);
      dec_tail1       = set_addr_cmd(4'd0, cursor_row_ff);
      dec_col         = cursor_col_ff;
      dec_row         = cursor_row_ff;
      dec_wr          = 1'b0;
      dec_clear_all   = 1'b0;
      lf_row          = (cursor_row_ff == LAST_ROW) ? LAST_ROW : cursor_row_ff + 2'd1;
      case (req_operation)
         OP_PUT_CHAR: begin
            case (req_character)
               CHAR_LF: begin
                  // scroll first when already on the bottom row
                  dec_scroll   = (cursor_row_ff == LAST_ROW);
                  dec_tail0    = set_addr_cmd(cursor_col_ff, lf_row);
                  dec_tail1    = set_addr_cmd(4'd0, lf_row);
                  dec_tail_cnt = auto_return_ff ? 2'd2 : 2'd1;
                  dec_row      = lf_row;
                  dec_col      = auto_return_ff ? 4'd0 : cursor_col_ff;
               end
               CHAR_CR: begin
                  dec_tail0    = set_addr_cmd(4'd0, cursor_row_ff);
                  dec_tail_cnt = 2'd1;
                  dec_col      = 4'd0;
               end
               CHAR_BS: begin
                  if (cursor_col_ff != 4'd0) begin
                     dec_tail0    = set_addr_cmd(cursor_col_ff - 4'd1, cursor_row_ff);
                     dec_tail_cnt = 2'd1;
                     dec_col      = cursor_col_ff - 4'd1;
                  end
               end
               default: begin
                  dec_first = 1'b1;
                  dec_wr    = (cursor_row_ff != 2'd0);
                  if (cursor_col_ff == LAST_COL) begin
                     dec_col = 4'd0;
                     if (cursor_row_ff != LAST_ROW) begin
                        dec_tail0    = set_addr_cmd(4'd0, cursor_row_ff + 2'd1);
                        dec_tail_cnt = 2'd1;
                        dec_row      = cursor_row_ff + 2'd1;
                     end else begin
                        dec_scroll = 1'b1;
                     end
                  end else begin
                     dec_col = cursor_col_ff + 4'd1;
                  end
               end
            endcase
         end
         OP_CLEAR: begin
            dec_first       = 1'b1;
            dec_first_clear = 1'b1;
            dec_clear_all   = 1'b1;
            dec_col         = 4'd0;
            dec_row         = 2'd0;
         end
         OP_SET_POS: begin
            if (({1'b0, req_pos_x} < 5'(COLUMNS)) && ({1'b0, req_pos_y} < 3'(ROWS))) begin
               dec_tail0    = set_addr_cmd(req_pos_x, req_pos_y);
               dec_tail_cnt = 2'd1;
               dec_col      = req_pos_x;
               dec_row      = req_pos_y;
            end
         end
         OP_RESTORE: begin
            if (saved_valid_ff) begin
               dec_tail0    = set_addr_cmd(saved_col_ff, saved_row_ff);
               dec_tail_cnt = 2'd1;
               dec_col      = saved_col_ff;
               dec_row      = saved_row_ff;
            end
         end
         default: begin
            // save cursor and unknown codes produce no bus writes
         end
      endcase
   end

   // write formed in the current state, and the state after it
   always_comb begin
      after_first  = scroll_ff ? S_CLEAR : ((tail_cnt_ff != 2'd0) ? S_TAIL0 : S_IDLE);
      after_scroll = (tail_cnt_ff != 2'd0) ? S_TAIL0 : S_IDLE;
      emit_cmd     = 1'b1;
      emit_byte    = CMD_CLEAR;
      emit_ms      = SETTLE_WRITE;
      emit_last    = 1'b0;
      emit_next    = state_ff;
      case (state_ff)
         S_FIRST: begin
            emit_cmd  = first_clear_ff;
            emit_byte = first_clear_ff ? CMD_CLEAR : first_byte_ff;
            emit_ms   = first_clear_ff ? SETTLE_CLEAR : SETTLE_WRITE;
            emit_last = !scroll_ff && (tail_cnt_ff == 2'd0);
            emit_next = after_first;
         end
         S_CLEAR: begin
            emit_ms   = SETTLE_CLEAR;
            emit_next = S_ROW_ADDR;
         end
         S_ROW_ADDR: begin
            emit_byte = set_addr_cmd(4'd0, row_cnt_ff);
            emit_next = S_ROW_DATA;
         end
         S_ROW_DATA: begin
            emit_cmd  = 1'b0;
            emit_byte = store_byte;
            if (col_cnt_ff != LAST_COL) begin
               emit_next = S_ROW_DATA;
            end else if (row_cnt_ff == LAST_STORE_ROW) begin
               emit_next = S_LAST_ADDR;
            end else begin
               emit_next = S_ROW_ADDR;
            end
         end
         S_LAST_ADDR: begin
            emit_byte = set_addr_cmd(4'd0, LAST_ROW);
            emit_last = (tail_cnt_ff == 2'd0);
            emit_next = after_scroll;
         end
         S_TAIL0: begin
            emit_byte = tail0_ff;
            emit_last = (tail_cnt_ff == 2'd1);
            emit_next = (tail_cnt_ff == 2'd2) ? S_TAIL1 : S_IDLE;
         end
         S_TAIL1: begin
            emit_byte = tail1_ff;
            emit_last = 1'b1;
            emit_next = S_IDLE;
         end
         default: begin
            emit_next = S_IDLE;
         end
      endcase
   end

   // row store requests: character write and clear at acceptance,
   // reads and row retirement during a scroll
   always_comb begin
      store_req           = '0;
      store_req.wr_en     = req_accept && (req_operation == OP_PUT_CHAR) && dec_wr;
      store_req.wr_row    = cursor_row_ff - 2'd1;
      store_req.wr_col    = cursor_col_ff;
      store_req.wr_data   = req_character;
      store_req.clear_all = req_accept && dec_clear_all;
      store_req.rd_row    = row_cnt_ff;
      store_req.rd_col    = 4'd0;
      if (emitting && (state_ff == S_ROW_ADDR)) begin
         store_req.rd_en = 1'b1;
      end
      if (emitting && (state_ff == S_ROW_DATA)) begin
         if (col_cnt_ff != LAST_COL) begin
            store_req.rd_en  = 1'b1;
            store_req.rd_col = col_cnt_ff + 4'd1;
         end else if (row_cnt_ff == LAST_STORE_ROW) begin
            store_req.scroll = 1'b1;
         end
      end
   end

   clt_row_store #(
      .ROWS (ROWS)
   ) u_row_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_byte   (store_byte)
   );

   // sequencer and cursor next state
   always_comb begin
      state_in       = state_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      saved_valid_in = saved_valid_ff;
      saved_col_in   = saved_col_ff;
      saved_row_in   = saved_row_ff;
      auto_return_in = (csr_valid && csr_ready) ? csr_auto_return : auto_return_ff;
      first_clear_in = first_clear_ff;
      first_byte_in  = first_byte_ff;
      scroll_in      = scroll_ff;
      tail_cnt_in    = tail_cnt_ff;
      tail0_in       = tail0_ff;
      tail1_in       = tail1_ff;
      row_cnt_in     = row_cnt_ff;
      col_cnt_in     = col_cnt_ff;
      if (req_accept) begin
         cursor_col_in  = dec_col;
         cursor_row_in  = dec_row;
         first_clear_in = dec_first_clear;
         first_byte_in  = req_character;
         scroll_in      = dec_scroll;
         tail_cnt_in    = dec_tail_cnt;
         tail0_in       = dec_tail0;
         tail1_in       = dec_tail1;
         row_cnt_in     = 2'd0;
         col_cnt_in     = 4'd0;
         if (req_operation == OP_SAVE) begin
            saved_valid_in = 1'b1;
            saved_col_in   = cursor_col_ff;
            saved_row_in   = cursor_row_ff;
         end
         if (dec_first) begin
            state_in = S_FIRST;
         end else if (dec_scroll) begin
            state_in = S_CLEAR;
         end else if (dec_tail_cnt != 2'd0) begin
            state_in = S_TAIL0;
         end
      end else if (emitting) begin
         state_in = emit_next;
         if (state_ff == S_ROW_DATA) begin
            if (col_cnt_ff != LAST_COL) begin
               col_cnt_in = col_cnt_ff + 4'd1;
            end else begin
               col_cnt_in = 4'd0;
               row_cnt_in = row_cnt_ff + 2'd1;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_last_in  = rsp_last_ff;
      if (emitting) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = emit_cmd;
         rsp_byte_in  = emit_byte;
         rsp_ms_in    = emit_ms;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cursor_col_ff  <= 4'd0;
         cursor_row_ff  <= 2'd0;
         saved_valid_ff <= 1'b0;
         saved_col_ff   <= 4'd0;
         saved_row_ff   <= 2'd0;
         auto_return_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         saved_valid_ff <= saved_valid_in;
         saved_col_ff   <= saved_col_in;
         saved_row_ff   <= saved_row_in;
         auto_return_ff <= auto_return_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_clear_ff <= first_clear_in;
      first_byte_ff  <= first_byte_in;
      scroll_ff      <= scroll_in;
      tail_cnt_ff    <= tail_cnt_in;
      tail0_ff       <= tail0_in;
      tail1_ff       <= tail1_in;
      row_cnt_ff     <= row_cnt_in;
      col_cnt_ff     <= col_cnt_in;
      rsp_cmd_ff     <= rsp_cmd_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_ms_ff      <= rsp_ms_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_command = rsp_cmd_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_settle_ms  = rsp_ms_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   a_cursor_in_panel: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cursor_col_ff} < 5'(COLUMNS)) && ({1'b0, cursor_row_ff} < 3'(ROWS)))
      else $error("cursor outside the panel");

   a_saved_in_panel: assert property (@(posedge clock) disable iff (reset)
      saved_valid_ff |-> ({1'b0, saved_col_ff} < 5'(COLUMNS)) &&
                         ({1'b0, saved_row_ff} < 3'(ROWS)))
      else $error("saved cursor outside the panel");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      emitting && emit_last |=> state_ff == S_IDLE)
      else $error("sequencer busy after the final write of a request");

   a_work_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && (dec_first || dec_scroll || (dec_tail_cnt != 2'd0))
      |=> state_ff != S_IDLE)
      else $error("request with bus writes did not start the sequencer");

   a_scroll_ends_rows: assert property (@(posedge clock) disable iff (reset)
      store_req.scroll |=> state_ff == S_LAST_ADDR || state_ff == S_ROW_DATA)
      else $error("row store retired a row outside the end of a scroll");

endmodule

/* tb/char_lcd_scrolling_terminal_unit_test.sv */
// ----------------------------------------------------------------------------
// char_lcd_scrolling_terminal_unit_test
// Self-checking bench for the scrolling character LCD terminal. A shadow
// terminal (cursor, saved cursor, lower row store, auto_return) predicts the
// bus writes of every request. Each write that leaves the unit is matched in
// order against that prediction. Directed tests cover the corner cases first,
// then random text and cursor traffic runs under both auto_return settings,
// with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module char_lcd_scrolling_terminal_unit_test;
   import clt_pkg::*;

   localparam int COLUMNS        = 16;
   localparam int ROWS           = 2;
   localparam int STORE_DEPTH    = (ROWS - 1) * COLUMNS;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic       is_command;
      logic [7:0] bus_byte;
      logic [2:0] settle_ms;
      logic       last;
   } bus_write_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // unit ports; the inputs are all known from time zero
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_operation  = OP_PUT_CHAR;
   logic [7:0] req_character  = '0;
   logic [3:0] req_pos_x      = '0;
   logic [1:0] req_pos_y      = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_is_command;
   logic [7:0] rsp_bus_byte;
   logic [2:0] rsp_settle_ms;
   logic       rsp_last;
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic       csr_auto_return = 1'b1;

   char_lcd_scrolling_terminal_unit #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_character  (req_character),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_command (rsp_is_command),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_settle_ms  (rsp_settle_ms),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_auto_return(csr_auto_return)
   );

   // shadow terminal state
   logic       auto_return_shadow = 1'b1;
   int         term_col = 0;
   int         term_row = 0;
   logic [7:0] lower_rows[STORE_DEPTH];
   logic       mark_valid = 1'b0;
   int         mark_col = 0;
   int         mark_row = 0;

   bus_write_type expected_writes[$];
   bus_write_type request_writes[$];

   // run statistics
   int failures       = 0;
   int requests_sent  = 0;
   int writes_checked = 0;
   int scroll_count   = 0;
   int csr_writes     = 0;
   int burst_left     = 0;

   initial begin
      foreach (lower_rows[i]) lower_rows[i] = CHAR_SPACE;
   end

   // ------------------------------------------------------------------------
   // shadow terminal
   // ------------------------------------------------------------------------
   function automatic void add_write(logic cmd, logic [7:0] value, logic [2:0] ms);
      bus_write_type w;
      w.is_command = cmd;
      w.bus_byte   = value;
      w.settle_ms  = ms;
      w.last       = 1'b0;
      request_writes.push_back(w);
   endfunction

   // set-address write; targets off the panel are dropped
   function automatic void move_cursor(int x, int y);
      logic [7:0] addr;
      if (x < COLUMNS && y < ROWS) begin
         term_col = x;
         term_row = y;
         addr = ROW_BASE[y] + 8'(x);
         add_write(1'b1, CMD_SET_ADDR | (addr & ADDR_MASK), SETTLE_WRITE);
      end
   endfunction

   function automatic void clear_panel();
      add_write(1'b1, CMD_CLEAR, SETTLE_CLEAR);
      term_col = 0;
      term_row = 0;
   endfunction

   // clear, redraw the stored rows one higher, shift the store up
   function automatic void scroll_panel();
      int idx;
      idx = 0;
      scroll_count++;
      clear_panel();
      for (int r = 0; r + 1 < ROWS; r++) begin
         move_cursor(0, r);
         for (int c = 0; c < COLUMNS; c++) begin
            add_write(1'b0, lower_rows[idx], SETTLE_WRITE);
            idx++;
         end
      end
      for (int i = 0; i < STORE_DEPTH; i++)
         lower_rows[i] = (i + COLUMNS < STORE_DEPTH) ? lower_rows[i + COLUMNS] : CHAR_SPACE;
      move_cursor(0, ROWS - 1);
   endfunction

   function automatic void line_feed();
      int keep;
      if (term_row < ROWS - 1) begin
         move_cursor(term_col, term_row + 1);
      end else begin
         keep = term_col;
         scroll_panel();
         move_cursor(keep, ROWS - 1);
      end
   endfunction

   function automatic void put_character(logic [7:0] ch);
      if (ch == CHAR_LF) begin
         line_feed();
         if (auto_return_shadow) move_cursor(0, term_row);
         return;
      end
      if (ch == CHAR_CR) begin
         move_cursor(0, term_row);
         return;
      end
      if (ch == CHAR_BS) begin
         if (term_col != 0) move_cursor(term_col - 1, term_row);
         return;
      end
      add_write(1'b0, ch, SETTLE_WRITE);
      if (term_row != 0) lower_rows[(term_row - 1) * COLUMNS + term_col] = ch;
      if (term_col >= COLUMNS - 1) begin
         if (term_row + 1 < ROWS) move_cursor(0, term_row + 1);
         else scroll_panel();
      end else begin
         term_col++;
      end
   endfunction

   // bus writes caused by one request; queued behind earlier ones
   function automatic int predict_bus_writes(logic [2:0] op, logic [7:0] ch,
                                             logic [3:0] px, logic [1:0] py);
      request_writes.delete();
      case (op)
         OP_PUT_CHAR: put_character(ch);
         OP_CLEAR: begin
            clear_panel();
            foreach (lower_rows[i]) lower_rows[i] = CHAR_SPACE;
         end
         OP_SET_POS: move_cursor(px, py);
         OP_SAVE: begin
            mark_valid = 1'b1;
            mark_col   = term_col;
            mark_row   = term_row;
         end
         OP_RESTORE: if (mark_valid) move_cursor(mark_col, mark_row);
         default: ;
      endcase
      if (request_writes.size() > 0) request_writes[request_writes.size() - 1].last = 1'b1;
      foreach (request_writes[i]) expected_writes.push_back(request_writes[i]);
      return request_writes.size();
   endfunction

   // ------------------------------------------------------------------------
   // request side: bursts of back-to-back requests with random gaps
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                               input logic [3:0] px, input logic [1:0] py,
                               output int n_writes);
      n_writes = predict_bus_writes(op, ch, px, py);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_character <= ch;
      req_pos_x     <= px;
      req_pos_y     <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 6);
      end
   endtask

   task automatic send_char(input logic [7:0] ch);
      int n;
      send_request(OP_PUT_CHAR, ch, 4'($urandom), 2'($urandom), n);
   endtask

   task automatic send_op(input logic [2:0] op, input logic [3:0] px, input logic [1:0] py);
      int n;
      send_request(op, 8'($urandom), px, py, n);
   endtask

   // stop requesting, let every predicted write drain, then let the unit settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_auto_return(input logic value);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_auto_return <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      auto_return_shadow = value;
      csr_writes++;
   endtask

   // ------------------------------------------------------------------------
   // receiver: stall pattern switches among free, random and long holds
   // ------------------------------------------------------------------------
   int   stall_mode      = 0;
   int   stall_mode_left = 0;
   int   stall_hold      = 0;
   logic stall_level     = 1'b0;

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 2);
         stall_mode_left = $urandom_range(20, 80);
      end
      stall_mode_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_hold == 0) begin
               stall_hold  = $urandom_range(1, 6);
               stall_level = ~stall_level;
            end
            stall_hold--;
            rsp_stall <= stall_level;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // result check: every accepted write against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bus_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         writes_checked++;
         if (expected_writes.size() == 0) begin
            $error("unexpected bus write: is_command %0d bus_byte %02h",
                   rsp_is_command, rsp_bus_byte);
            failures++;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_is_command !== want.is_command) begin
               $error("is_command: expected %0d, actual %0d", want.is_command, rsp_is_command);
               failures++;
            end
            if (rsp_bus_byte !== want.bus_byte) begin
               $error("bus_byte: expected %02h, actual %02h", want.bus_byte, rsp_bus_byte);
               failures++;
            end
            if (rsp_settle_ms !== want.settle_ms) begin
               $error("settle_ms: expected %0d, actual %0d", want.settle_ms, rsp_settle_ms);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // restore before any save must write nothing
   task automatic test_restore_without_save();
      send_op(OP_RESTORE, 4'd3, 2'd1);
   endtask

   // byte extremes and wrap from the last column of the top row
   task automatic test_characters();
      send_char(8'h00);
      send_char(8'hFF);
      send_op(OP_SET_POS, 4'(COLUMNS - 1), 2'd0);
      send_char("A");
   endtask

   // backspace at column zero is a no-op; backspace and return move the cursor
   task automatic test_control_characters();
      send_char(CHAR_BS);
      send_char("B");
      send_char(CHAR_BS);
      send_char("D");
      send_char(CHAR_CR);
   endtask

   // last column of the bottom row scrolls, then line feed on the bottom row
   task automatic test_scrolling();
      send_op(OP_SET_POS, 4'(COLUMNS - 1), 2'(ROWS - 1));
      send_op(OP_SAVE, 4'd0, 2'd0);
      send_char("C");
      send_char(CHAR_LF);
   endtask

   // restore, corner position, rows off the panel are ignored
   task automatic test_cursor_ops();
      send_op(OP_RESTORE, 4'd0, 2'd0);
      send_op(OP_SET_POS, 4'd0, 2'd0);
      send_op(OP_SET_POS, 4'd15, 2'd3);
      send_op(OP_SET_POS, 4'd3, 2'd2);
   endtask

   // operation codes past restore do nothing
   task automatic test_ignored_ops();
      for (int code = OP_RESTORE + 1; code < 8; code++)
         send_op(3'(code), 4'($urandom), 2'($urandom));
   endtask

   // clear empties the store but keeps the saved cursor
   task automatic test_clear_screen();
      send_op(OP_CLEAR, 4'($urandom), 2'($urandom));
      send_op(OP_RESTORE, 4'($urandom), 2'($urandom));
   endtask

   // line feed keeps the column while auto_return is off
   task automatic test_line_feed_modes();
      write_auto_return(1'b0);
      send_op(OP_SET_POS, 4'd5, 2'd0);
      send_char(CHAR_LF);
      send_char(CHAR_LF);
      write_auto_return(1'b1);
   endtask

   // mostly text with line breaks, mixed with cursor requests and some noise
   task automatic test_random_traffic(input int item_goal);
      int         done_items;
      int         pick;
      int         n;
      logic [2:0] op;
      logic [7:0] ch;
      done_items = 0;
      while (done_items < item_goal) begin
         pick = $urandom_range(0, 99);
         ch   = 8'($urandom);
         if (pick < 60) begin
            op = OP_PUT_CHAR;
            case ($urandom_range(0, 9))
               0: ch = CHAR_LF;
               1: ch = CHAR_CR;
               2: ch = CHAR_BS;
               default: ;
            endcase
         end else if (pick < 75) op = OP_SET_POS;
         else if (pick < 80) op = OP_CLEAR;
         else if (pick < 87) op = OP_SAVE;
         else if (pick < 94) op = OP_RESTORE;
         else op = 3'($urandom_range(OP_RESTORE + 1, 7));
         send_request(op, ch, 4'($urandom), 2'($urandom), n);
         done_items++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_restore_without_save();
      test_characters();
      test_control_characters();
      test_scrolling();
      test_cursor_ops();
      test_ignored_ops();
      test_clear_screen();
      test_line_feed_modes();

      write_auto_return(1'b0);
      test_random_traffic(40);
      write_auto_return(1'b1);
      test_random_traffic(40);
      write_auto_return(1'($urandom));
      test_random_traffic(40);

      wait_idle();
      $display("Covered %0d requests, %0d bus writes checked, %0d scrolls.",
               requests_sent, writes_checked, scroll_count);
      $display("auto_return written %0d times, both settings exercised.", csr_writes);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
